### design/elb_pkg.sv
`default_nettype none

package elb_pkg;

    // Widths of the item fields
    localparam int LINE_W       = 15;
    localparam int FUNC_W       = 2;
    localparam int PIX_W        = 64;
    localparam int SCAN_POS_W   = LINE_W - 2;

    // Default sizes of the line
    localparam int LINE_BYTES_DEF = 16;
    localparam int SCAN_BYTES_DEF = 24;

    // Fixed bytes of the stream
    localparam logic [7:0] HEADER_BYTE = 8'h72;
    localparam logic [7:0] BORDER_BYTE = 8'h00;
    localparam logic [7:0] FILL_BYTE   = 8'h00;
    localparam logic [7:0] SCAN_MARK   = 8'hC0;

    // Update stages carried on func
    localparam logic [FUNC_W-1:0] FUNC_COMP    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WHITE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INVERSE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NORMAL  = 2'd3;

    // Configuration register indexes
    localparam logic REG_FILLER = 1'b0;

    // Recoded even and odd byte of one pixel byte
    typedef struct packed {
        logic [7:0] even_code;
        logic [7:0] odd_code;
    } code_t;

    // Scan position of one line
    typedef struct packed {
        logic [SCAN_POS_W-1:0] scan_pos;
        logic [1:0]            scan_sel;
    } line_info_t;

endpackage

`default_nettype wire

### design/eink_line_byte_stream_encoder_core.sv
`default_nettype none

// Channel    | Handshake               | Payload
// -----------+-------------------------+--------------------------------------------
// line in    | in_valid / in_ready     | line_index, use_fixed, fixed_byte, func,
//            |                         | pixels_low, pixels_high
// byte out   | out_valid / out_ready   | out_byte, last
// config     | psel/penable/pwrite/... | register 0 (byte address 0): insert_filler
//
// The byte serializer streams one line at one byte per cycle while out_ready is high:
// 2 + 2*LINE_BYTES + SCAN_BYTES bytes (58 at the defaults), one more with the filler on.
// A line is accepted into a one-deep buffer while the previous line still streams,
// and the serializer picks it up on the cycle it sends the final byte, so lines
// follow each other with no gap. Reset clears the buffer, sequencer and register;
// no clearing pass is needed. A low out_ready holds the stream in place.

module eink_line_byte_stream_encoder_core #(
    parameter int LINE_BYTES = elb_pkg::LINE_BYTES_DEF,
    parameter int SCAN_BYTES = elb_pkg::SCAN_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // line transaction in
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [elb_pkg::LINE_W-1:0]    line_index,
    input  wire logic                          use_fixed,
    input  wire logic [7:0]                    fixed_byte,
    input  wire logic [elb_pkg::FUNC_W-1:0]    func,
    input  wire logic [elb_pkg::PIX_W-1:0]     pixels_low,
    input  wire logic [elb_pkg::PIX_W-1:0]     pixels_high,

    // byte transaction out
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [7:0]                         out_byte,
    output logic                               last,

    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic                                 filler_reg, filler_next;
    logic                                 cfg_wr;

    logic [2*elb_pkg::PIX_W-1:0]          pix_all;
    elb_pkg::code_t [LINE_BYTES-1:0]      lane_code;

    logic                                 buf_valid_reg, buf_valid_next;
    logic [LINE_BYTES-1:0][7:0]           even_buf_reg;
    logic [LINE_BYTES-1:0][7:0]           odd_buf_reg;
    elb_pkg::line_info_t                  info_buf_reg;
    elb_pkg::line_info_t                  info_in;

    logic                                 in_take;
    logic                                 line_ready;

    // -------------------------------------------------------------------------
    // Configuration register: written on the access phase, always ready
    // -------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        filler_next = filler_reg;
        if (cfg_wr && (paddr[2] == elb_pkg::REG_FILLER))
        begin
            filler_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filler_reg <= 1'b0;
        end
        else
        begin
            filler_reg <= filler_next;
        end
    end

    assign prdata = (paddr[2] == elb_pkg::REG_FILLER) ? {31'd0, filler_reg} : 32'd0;

    // -------------------------------------------------------------------------
    // Lanes: one recoder per pixel byte, all working on the incoming line
    // -------------------------------------------------------------------------
    assign pix_all = {pixels_high, pixels_low};

    for (genvar g = 0; g < LINE_BYTES; g++)
    begin : g_lane
        elb_lane u_lane (
            .raw_byte   (pix_all[8*g +: 8]),
            .use_fixed  (use_fixed),
            .fixed_byte (fixed_byte),
            .func       (func),
            .code       (lane_code[g])
        );
    end

    // Scan byte position and the shift that places the mark in it
    assign info_in.scan_pos = line_index[elb_pkg::LINE_W-1:2];
    assign info_in.scan_sel = line_index[1:0];

    // -------------------------------------------------------------------------
    // Line buffer: hold one recoded line until the serializer takes it
    // -------------------------------------------------------------------------
    assign in_ready = !buf_valid_reg || line_ready;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        if (in_take)
        begin
            buf_valid_next = 1'b1;
        end
        else if (line_ready)
        begin
            buf_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < LINE_BYTES; i++)
            begin
                even_buf_reg[i] <= lane_code[i].even_code;
                odd_buf_reg[i]  <= lane_code[i].odd_code;
            end
            info_buf_reg <= info_in;
        end
    end

    // -------------------------------------------------------------------------
    // Serializer: header, border, even, scan, odd and optional filler bytes in order
    // -------------------------------------------------------------------------
    elb_merge #(
        .LINE_BYTES (LINE_BYTES),
        .SCAN_BYTES (SCAN_BYTES)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .line_valid    (buf_valid_reg),
        .line_ready    (line_ready),
        .even_bytes    (even_buf_reg),
        .odd_bytes     (odd_buf_reg),
        .line_info     (info_buf_reg),
        .insert_filler (filler_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last          (last)
    );

endmodule

`default_nettype wire

### design/elb_lane.sv
`default_nettype none

module elb_lane (
    input  wire logic       [7:0] raw_byte,
    input  wire logic             use_fixed,
    input  wire logic       [7:0] fixed_byte,
    input  wire logic       [1:0] func,
    output elb_pkg::code_t        code
);

    logic [7:0] even_p;
    logic [7:0] even_inv;
    logic [7:0] even_v;
    logic [7:0] odd_p;
    logic [7:0] odd_inv;
    logic [7:0] odd_v;

    assign even_p   = raw_byte & 8'hAA;
    assign even_inv = even_p ^ 8'hAA;
    assign odd_p    = raw_byte & 8'h55;
    assign odd_inv  = odd_p ^ 8'h55;

    always_comb
    begin
        case (func)
            elb_pkg::FUNC_COMP:    even_v = 8'hAA | (even_inv >> 1);
            elb_pkg::FUNC_WHITE:   even_v = 8'h55 + (even_inv >> 1);
            elb_pkg::FUNC_INVERSE: even_v = 8'h55 | even_inv;
            elb_pkg::FUNC_NORMAL:  even_v = 8'hAA | (even_p >> 1);
            default:               even_v = 8'hAA | (even_p >> 1);
        endcase
    end

    always_comb
    begin
        case (func)
            elb_pkg::FUNC_COMP:    odd_v = 8'hAA | odd_inv;
            elb_pkg::FUNC_WHITE:   odd_v = 8'h55 + odd_inv;
            elb_pkg::FUNC_INVERSE: odd_v = 8'h55 | (odd_inv << 1);
            elb_pkg::FUNC_NORMAL:  odd_v = 8'hAA | odd_p;
            default:               odd_v = 8'hAA | odd_p;
        endcase
    end

    // Fixed bytes go out as they are; odd codes have their pixel pairs reversed
    assign code.even_code = use_fixed ? fixed_byte : even_v;
    assign code.odd_code  = use_fixed ? fixed_byte
                                      : {odd_v[1:0], odd_v[3:2], odd_v[5:4], odd_v[7:6]};

endmodule

`default_nettype wire

### design/elb_merge.sv
`default_nettype none

module elb_merge #(
    parameter int LINE_BYTES = elb_pkg::LINE_BYTES_DEF,
    parameter int SCAN_BYTES = elb_pkg::SCAN_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        line_valid,
    output logic                             line_ready,
    input  wire logic [LINE_BYTES-1:0][7:0]  even_bytes,
    input  wire logic [LINE_BYTES-1:0][7:0]  odd_bytes,
    input  wire elb_pkg::line_info_t         line_info,
    input  wire logic                        insert_filler,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       out_byte,
    output logic                             last
);

    localparam int SEG_MAX = (LINE_BYTES > SCAN_BYTES) ? LINE_BYTES : SCAN_BYTES;
    localparam int CNT_W   = $clog2(SEG_MAX + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_BORDER,
        ST_EVEN,
        ST_SCAN,
        ST_ODD,
        ST_FILL
    } state_t;

    state_t                        state_reg,    state_next;
    logic [CNT_W-1:0]              cnt_reg,      cnt_next;
    logic [LINE_BYTES-1:0][7:0]    even_sh_reg,  even_sh_next;
    logic [LINE_BYTES-1:0][7:0]    odd_sh_reg,   odd_sh_next;
    elb_pkg::line_info_t           info_reg,     info_next;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_byte_reg, out_byte_next;
    logic                          last_reg,     last_next;

    logic                          adv;
    logic                          final_byte;
    logic                          load;
    logic [7:0]                    emit_byte;
    logic [7:0]                    scan_val;
    logic                          seg_end_line;
    logic                          seg_end_scan;

    assign adv          = !out_valid_reg || out_ready;
    assign scan_val     = elb_pkg::SCAN_MARK >> {info_reg.scan_sel, 1'b0};
    assign seg_end_line = (cnt_reg == CNT_W'(LINE_BYTES - 1));
    assign seg_end_scan = (cnt_reg == CNT_W'(SCAN_BYTES - 1));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        even_sh_next   = even_sh_reg;
        odd_sh_next    = odd_sh_reg;
        info_next      = info_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        emit_byte      = elb_pkg::BORDER_BYTE;
        final_byte     = 1'b0;

        case (state_reg)
            ST_IDLE:   emit_byte = elb_pkg::BORDER_BYTE;
            ST_HDR:    emit_byte = elb_pkg::HEADER_BYTE;
            ST_BORDER: emit_byte = elb_pkg::BORDER_BYTE;
            ST_EVEN:   emit_byte = even_sh_reg[LINE_BYTES-1];
            ST_SCAN:
            begin
                emit_byte = (elb_pkg::SCAN_POS_W'(cnt_reg) == info_reg.scan_pos)
                          ? scan_val : 8'h00;
            end
            ST_ODD:
            begin
                emit_byte  = odd_sh_reg[0];
                final_byte = seg_end_line && !insert_filler;
            end
            ST_FILL:
            begin
                emit_byte  = elb_pkg::FILL_BYTE;
                final_byte = 1'b1;
            end
            default:   emit_byte = elb_pkg::BORDER_BYTE;
        endcase

        if (adv)
        begin
            out_valid_next = (state_reg != ST_IDLE);
            out_byte_next  = emit_byte;
            last_next      = final_byte;

            case (state_reg)
                ST_IDLE:   state_next = ST_IDLE;
                ST_HDR:    state_next = ST_BORDER;
                ST_BORDER:
                begin
                    state_next = ST_EVEN;
                    cnt_next   = '0;
                end
                ST_EVEN:
                begin
                    // advance the even bytes toward the output end
                    for (int i = 1; i < LINE_BYTES; i++)
                    begin
                        even_sh_next[i] = even_sh_reg[i-1];
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (seg_end_line)
                    begin
                        state_next = ST_SCAN;
                        cnt_next   = '0;
                    end
                end
                ST_SCAN:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (seg_end_scan)
                    begin
                        state_next = ST_ODD;
                        cnt_next   = '0;
                    end
                end
                ST_ODD:
                begin
                    for (int i = 0; i < LINE_BYTES - 1; i++)
                    begin
                        odd_sh_next[i] = odd_sh_reg[i+1];
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (seg_end_line)
                    begin
                        state_next = insert_filler ? ST_FILL : ST_IDLE;
                        cnt_next   = '0;
                    end
                end
                ST_FILL:   state_next = ST_IDLE;
                default:   state_next = ST_IDLE;
            endcase
        end

        // take the next line when idle, or on the cycle the current one sends its final byte
        load = line_valid && ((state_reg == ST_IDLE) || (adv && final_byte));
        if (load)
        begin
            even_sh_next = even_bytes;
            odd_sh_next  = odd_bytes;
            info_next    = line_info;
            state_next   = ST_HDR;
            cnt_next     = '0;
        end
    end

    assign line_ready = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        even_sh_reg <= even_sh_next;
        odd_sh_reg  <= odd_sh_next;
        info_reg    <= info_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    // A header only starts once the previous line has shown its final byte
    a_hdr_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HDR) |-> (!out_valid_reg || last_reg))
        else $error("header pending while a line is unfinished");

    // The scan segment is always preceded by an emitted even byte
    a_scan_has_even: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && (cnt_reg == '0)) |-> out_valid_reg)
        else $error("scan segment entered without even bytes");

    // A pending final byte leaves the sequencer idle or at a new header
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> ((state_reg == ST_IDLE) || (state_reg == ST_HDR)))
        else $error("final byte shown while a line is still streaming");

    // A taken line always moves the sequencer to a new header
    a_load_point: assert property (@(posedge clk) disable iff (!rst_n)
        (line_valid && line_ready) |=> (state_reg == ST_HDR))
        else $error("line taken without starting a header");

endmodule

`default_nettype wire

### bench/tb_eink_line_byte_stream_encoder_core.sv
`default_nettype none

module tb_eink_line_byte_stream_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PIX  = elb_pkg::LINE_BYTES_DEF;
    localparam int NUM_SCAN = elb_pkg::SCAN_BYTES_DEF;
    localparam int LINE_W   = elb_pkg::LINE_W;
    localparam int PIX_W    = elb_pkg::PIX_W;
    localparam int FUNC_W   = elb_pkg::FUNC_W;

    // Byte address of the filler register
    localparam logic [2:0] ADDR_FILLER = 3'(4 * elb_pkg::REG_FILLER);

    localparam int LONG_HOLD     = 400;   // receiver hold-off, in cycles
    localparam int QUIET_LIMIT   = 3000;  // cycles without any transaction before giving up
    localparam int TAIL_CYCLES   = 80;    // settle time after the last expected byte
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [LINE_W-1:0] line_index;
        logic              use_fixed;
        logic [7:0]        fixed_byte;
        logic [1:0]        func;
        logic [PIX_W-1:0]  pixels_low;
        logic [PIX_W-1:0]  pixels_high;
    } line_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    logic              in_valid;
    logic              in_ready;
    logic [LINE_W-1:0] line_index;
    logic              use_fixed;
    logic [7:0]        fixed_byte;
    logic [FUNC_W-1:0] func;
    logic [PIX_W-1:0]  pixels_low;
    logic [PIX_W-1:0]  pixels_high;

    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       last;

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Bytes still owed by the block, oldest first
    stream_byte_t stream_q[$];

    // Shadow of the filler register as the block should hold it
    logic filler_shadow;

    int  mismatches;
    int  quiet_cycles;
    bit  idle_on;        // random gaps on both sides when set
    bit  hold_request;   // ask the byte sink for one long hold-off

    eink_line_byte_stream_encoder_core dut (.*);

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Stream prediction
    // ------------------------------------------------------------------

    // Even pixel byte: keep bits 0xAA, then recode for the stage
    function automatic logic [7:0] even_recode(input logic [7:0] raw, input logic [1:0] stage);
        logic [7:0] kept;
        logic [7:0] flipped;
        kept    = raw & 8'hAA;
        flipped = kept ^ 8'hAA;
        case (stage)
            elb_pkg::FUNC_COMP:    return 8'hAA | (flipped >> 1);
            elb_pkg::FUNC_WHITE:   return 8'h55 + (flipped >> 1);
            elb_pkg::FUNC_INVERSE: return 8'h55 | flipped;
            default:               return 8'hAA | (kept >> 1);
        endcase
    endfunction

    // Odd pixel byte: keep bits 0x55, recode, then reverse the four bit pairs
    function automatic logic [7:0] odd_recode(input logic [7:0] raw, input logic [1:0] stage);
        logic [7:0] kept;
        logic [7:0] flipped;
        logic [7:0] coded;
        kept    = raw & 8'h55;
        flipped = kept ^ 8'h55;
        case (stage)
            elb_pkg::FUNC_COMP:    coded = 8'hAA | flipped;
            elb_pkg::FUNC_WHITE:   coded = 8'h55 + flipped;
            elb_pkg::FUNC_INVERSE: coded = 8'h55 | (flipped << 1);
            default:               coded = 8'hAA | kept;
        endcase
        return {coded[1:0], coded[3:2], coded[5:4], coded[7:6]};
    endfunction

    // Append the whole byte stream that one accepted line must produce
    function automatic void queue_line_stream(input line_item_t it);
        logic [2*PIX_W-1:0] pix;
        logic [7:0]         scan_val;
        logic [7:0]         pb;
        pix      = {it.pixels_high, it.pixels_low};
        scan_val = 8'hC0 >> (2 * it.line_index[1:0]);
        stream_q.push_back('{data: elb_pkg::HEADER_BYTE, last: 1'b0});
        stream_q.push_back('{data: elb_pkg::BORDER_BYTE, last: 1'b0});
        for (int b = NUM_PIX - 1; b >= 0; b--) begin
            pb = it.use_fixed ? it.fixed_byte : even_recode(pix[8*b +: 8], it.func);
            stream_q.push_back('{data: pb, last: 1'b0});
        end
        // Lines past the scan range match no slot and send all zeros
        for (int b = 0; b < NUM_SCAN; b++) begin
            pb = (b == int'(it.line_index >> 2)) ? scan_val : 8'h00;
            stream_q.push_back('{data: pb, last: 1'b0});
        end
        for (int b = 0; b < NUM_PIX; b++) begin
            pb = it.use_fixed ? it.fixed_byte : odd_recode(pix[8*b +: 8], it.func);
            stream_q.push_back('{data: pb, last: (b == NUM_PIX - 1) && !filler_shadow});
        end
        if (filler_shadow)
            stream_q.push_back('{data: elb_pkg::FILL_BYTE, last: 1'b1});
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    // ------------------------------------------------------------------
    // Byte checker and watchdog
    // ------------------------------------------------------------------

    // Compare every byte transaction with the oldest owed byte. Any handshake on any
    // port counts as progress; a long silence means the block has hung.
    always @(posedge clk) begin
        stream_byte_t want;
        if (rst_n && out_valid && out_ready) begin
            if (stream_q.size() == 0) begin
                note_mismatch($sformatf("byte %h last %b with nothing owed", out_byte, last));
            end else begin
                want = stream_q.pop_front();
                if (out_byte !== want.data || last !== want.last)
                    note_mismatch($sformatf("byte expected %h last %b, got %h last %b",
                                            want.data, want.last, out_byte, last));
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Byte sink: drives out_ready at the falling edge
    // ------------------------------------------------------------------

    // Drop ready in short random bursts while idling is on, and for one long
    // stretch whenever a hold-off is requested so the block backs up into its input.
    initial begin : byte_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Each starts at a falling edge and returns at one with no
    // pending assignment made in that step.
    // ------------------------------------------------------------------

    // Offer one line transaction; hold valid and payload until accepted, then
    // queue its predicted stream. Valid stays high for a back-to-back follower.
    task automatic send_line(input line_item_t it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        line_index  <= it.line_index;
        use_fixed   <= it.use_fixed;
        fixed_byte  <= it.fixed_byte;
        func        <= it.func;
        pixels_low  <= it.pixels_low;
        pixels_high <= it.pixels_high;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        queue_line_stream(it);
        @(negedge clk);
    endtask

    task automatic stop_lines();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Hold the line side quiet until every owed byte has come out
    task automatic wait_drained();
        stop_lines();
        while (stream_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr == ADDR_FILLER)
            filler_shadow = data[0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_filler_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_FILLER;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== {31'b0, filler_shadow})
            note_mismatch($sformatf("filler register expected %h, read %h",
                                    {31'b0, filler_shadow}, prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic line_item_t make_line(input logic [LINE_W-1:0] idx,
                                             input logic [1:0] stage,
                                             input logic [2*PIX_W-1:0] pix);
        line_item_t it;
        it.line_index  = idx;
        it.use_fixed   = 1'b0;
        it.fixed_byte  = 8'($urandom);
        it.func        = stage;
        it.pixels_low  = pix[PIX_W-1:0];
        it.pixels_high = pix[2*PIX_W-1:PIX_W];
        return it;
    endfunction

    function automatic logic [2*PIX_W-1:0] random_pixels();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Mostly lines inside the scan range, some dummy lines and the index extremes
    function automatic line_item_t random_line();
        line_item_t it;
        logic [LINE_W-1:0] idx;
        case ($urandom_range(0, 9))
            0:       idx = LINE_W'($urandom_range(4 * NUM_SCAN, 32767));
            1:       idx = $urandom_range(0, 1) ? '1 : LINE_W'(4 * NUM_SCAN);
            2:       idx = $urandom_range(0, 1) ? '0 : LINE_W'(4 * NUM_SCAN - 1);
            default: idx = LINE_W'($urandom_range(0, 4 * NUM_SCAN - 1));
        endcase
        it = make_line(idx, 2'($urandom), random_pixels());
        it.use_fixed = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Read the reset value, then flip the register both ways
    task automatic test_register_access();
        check_filler_readback();
        reg_write(ADDR_FILLER, 32'd1);
        check_filler_readback();
        reg_write(ADDR_FILLER, 32'd0);
        check_filler_readback();
    endtask

    // Every stage on flat and ordered pixel patterns, fixed-byte lines,
    // the last scan slot, the first dummy line and the top line index
    task automatic test_directed_lines();
        line_item_t it;
        logic [2*PIX_W-1:0] pattern;
        for (int s = 0; s < 4; s++) begin
            for (int p = 0; p < 3; p++) begin
                case (p)
                    0:       pattern = '0;
                    1:       pattern = '1;
                    default: pattern = 128'h0F1E2D3C4B5A69788796A5B4C3D2E1F0;
                endcase
                send_line(make_line(LINE_W'(4 * s + p), 2'(s), pattern));
            end
        end
        it = make_line(LINE_W'(5), elb_pkg::FUNC_INVERSE, random_pixels());
        it.use_fixed  = 1'b1;
        it.fixed_byte = 8'h00;
        send_line(it);
        it = make_line(LINE_W'(6), elb_pkg::FUNC_NORMAL, random_pixels());
        it.use_fixed  = 1'b1;
        it.fixed_byte = 8'hFF;
        send_line(it);
        send_line(make_line(LINE_W'(4 * NUM_SCAN - 4), elb_pkg::FUNC_NORMAL,
                            random_pixels()));
        send_line(make_line(LINE_W'(4 * NUM_SCAN - 1), elb_pkg::FUNC_WHITE,
                            random_pixels()));
        send_line(make_line(LINE_W'(4 * NUM_SCAN), elb_pkg::FUNC_COMP, random_pixels()));
        send_line(make_line('1, elb_pkg::FUNC_INVERSE, random_pixels()));
        wait_drained();
    endtask

    // Same stages with the trailing filler byte switched on
    task automatic test_filler_lines();
        line_item_t it;
        reg_write(ADDR_FILLER, 32'd1);
        check_filler_readback();
        for (int s = 0; s < 4; s++)
            send_line(make_line(LINE_W'($urandom_range(0, 4 * NUM_SCAN - 1)), 2'(s),
                                random_pixels()));
        it = random_line();
        it.use_fixed = 1'b1;
        send_line(it);
        wait_drained();
        reg_write(ADDR_FILLER, 32'd0);
    endtask

    // Hold the byte side off for a long stretch while lines keep coming,
    // so the buffer fills and in_ready drops
    task automatic test_output_holdoff();
        hold_request = 1'b1;
        for (int i = 0; i < 8; i++)
            send_line(random_line());
        wait_drained();
    endtask

    // Pause the line side until the block has emptied, then resume
    task automatic test_sender_pause();
        for (int i = 0; i < 3; i++)
            send_line(random_line());
        wait_drained();
        for (int i = 0; i < 3; i++)
            send_line(random_line());
        wait_drained();
    endtask

    // Random lines in chunks; change the filler setting between chunks, drop
    // idling for the third chunk and for the whole last one
    task automatic test_random_lines();
        for (int chunk = 0; chunk < 6; chunk++) begin
            wait_drained();
            reg_write(ADDR_FILLER, 32'(chunk % 2));
            idle_on = (chunk != 5) && (chunk != 2);
            for (int i = 0; i < 48; i++)
                send_line(random_line());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : run
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        line_index    = '0;
        use_fixed     = 1'b0;
        fixed_byte    = '0;
        func          = '0;
        pixels_low    = '0;
        pixels_high   = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        filler_shadow = 1'b0;
        mismatches    = 0;
        quiet_cycles  = 0;
        idle_on       = 1'b1;
        hold_request  = 1'b0;

        // Hold reset, then release it away from the rising edge
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_access();
        test_directed_lines();
        test_filler_lines();
        test_output_holdoff();
        test_sender_pause();
        test_random_lines();

        // Drain, then give any stray extra byte time to show up
        stop_lines();
        while (stream_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
